>>> design/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths, word types and cell state for the triangle unit normal.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int CW = 24;          // vertex coordinate width
  localparam int F  = 15;          // fraction bits of a normal component
  localparam int DW = CW + 1;      // edge vector component width
  localparam int MW = 2 * DW;      // cross product magnitude width
  localparam int SW = 2 * MW + 2;  // squared length width
  localparam int RW = 2 * MW + 2 * F + 6;  // residual width, signed
  localparam int QW = F + 1;       // quotient width, holds 2^F
  localparam int NCELLS = F + 1;
  localparam int KW = $clog2(NCELLS);

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic signed [CW-1:0] third_z;
  } tri_word_t;

  typedef struct packed {
    logic signed [F:0] unit_x;
    logic signed [F:0] unit_y;
    logic signed [F:0] unit_z;
    logic              degenerate;
  } norm_word_t;

  // state handed from cell to cell, one lane per component
  typedef struct packed {
    logic                   valid;
    logic                   degenerate;
    logic [2:0]             neg;
    logic [SW-1:0]          s;
    logic [2:0][RW-1:0]     r;
    logic [2:0][RW-1:0]     p;
    logic [2:0][QW-1:0]     q;
  } cell_t;

endpackage

>>> design/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle, signed Q1.15 components, degenerate flag.
// ----------------------------------------------------------------------------
// Takes one triangle word per cycle while not stalled and returns one normal
// word per triangle, in order, through seven front stages (edges, cross
// product, magnitude, split squares, square sum, residual seed), one cell per
// quotient bit (16 cells, all three components in parallel) and the output
// register. Every stage moves on a shared enable that stops only while a
// finished word waits in the output register under stall, so tri_stall
// follows norm_stall through that register.
module triangle_unit_normal (
  input  logic                clk,
  input  logic                rst,
  input  logic                tri_valid,
  output logic                tri_stall,
  input  tun_pkg::tri_word_t  triangle,
  output logic                norm_valid,
  input  logic                norm_stall,
  output tun_pkg::norm_word_t normal
);
  import tun_pkg::*;

  logic       en;
  cell_t      chain [NCELLS+1];
  norm_word_t normal_next;
  logic [F:0] comp [3];

  assign en        = !(norm_valid && norm_stall);
  assign tri_stall = !en;

  tun_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .tri_valid (tri_valid),
    .triangle  (triangle),
    .head      (chain[0])
  );

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    tun_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bit_pos (KW'(F - g)),
      .prev    (chain[g]),
      .cur     (chain[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (chain[NCELLS].degenerate) begin
        comp[i] = '0;
      end else if (chain[NCELLS].neg[i]) begin
        comp[i] = (F+1)'(-chain[NCELLS].q[i]);
      end else if (chain[NCELLS].q[i][F]) begin
        comp[i] = {1'b0, {F{1'b1}}};  // +1.0 saturates
      end else begin
        comp[i] = chain[NCELLS].q[i];
      end
    end
    normal_next.unit_x     = comp[0];
    normal_next.unit_y     = comp[1];
    normal_next.unit_z     = comp[2];
    normal_next.degenerate = chain[NCELLS].degenerate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
    end else if (en) begin
      norm_valid <= chain[NCELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal <= normal_next;
    end
  end

endmodule

>>> design/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, cross product, squared length and seed of the divide chain.
// ----------------------------------------------------------------------------
module tun_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               tri_valid,
  input  tun_pkg::tri_word_t triangle,
  output tun_pkg::cell_t     head
);
  import tun_pkg::*;

  logic [5:0] v;

  logic signed [DW-1:0]   ax, ay, az, bx, by, bz;
  logic signed [2*DW-1:0] prod [6];
  logic [MW-1:0]          mag  [3];
  logic [2:0]             neg3, neg4, neg5, neg6;
  logic [MW-1:0]          hh [3];
  logic [MW-1:0]          hl [3];
  logic [MW-1:0]          ll [3];
  logic [2*MW-1:0]        sq [3];
  logic [2*MW-1:0]        sq6 [3];
  logic [SW-1:0]          s6;
  logic                   deg6;

  logic signed [2*DW:0] c [3];
  cell_t                head_next;

  always_comb begin
    c[0] = (2*DW+1)'(prod[0]) - (2*DW+1)'(prod[1]);
    c[1] = (2*DW+1)'(prod[2]) - (2*DW+1)'(prod[3]);
    c[2] = (2*DW+1)'(prod[4]) - (2*DW+1)'(prod[5]);
  end

  always_comb begin
    head_next = '0;
    head_next.valid      = v[5];
    head_next.degenerate = deg6;
    head_next.neg        = neg6;
    head_next.s          = s6;
    for (int i = 0; i < 3; i++) begin
      head_next.r[i] = (RW'(sq6[i]) << (2 * F + 2)) - RW'(s6);
      head_next.p[i] = RW'(0) - RW'(s6);
      head_next.q[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      head.valid <= 1'b0;
    end else if (en) begin
      v    <= {v[4:0], tri_valid};
      head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= DW'(triangle.second_x) - DW'(triangle.first_x);
      ay <= DW'(triangle.second_y) - DW'(triangle.first_y);
      az <= DW'(triangle.second_z) - DW'(triangle.first_z);
      bx <= DW'(triangle.third_x) - DW'(triangle.first_x);
      by <= DW'(triangle.third_y) - DW'(triangle.first_y);
      bz <= DW'(triangle.third_z) - DW'(triangle.first_z);

      prod[0] <= ay * bz;
      prod[1] <= az * by;
      prod[2] <= az * bx;
      prod[3] <= ax * bz;
      prod[4] <= ax * by;
      prod[5] <= ay * bx;

      for (int i = 0; i < 3; i++) begin
        neg3[i] <= c[i][2*DW];
        mag[i]  <= c[i][2*DW] ? MW'(-c[i]) : MW'(c[i]);
      end
      neg4 <= neg3;

      // square split into halves to keep each multiplier narrow
      for (int i = 0; i < 3; i++) begin
        hh[i] <= mag[i][MW-1:DW] * mag[i][MW-1:DW];
        hl[i] <= mag[i][MW-1:DW] * mag[i][DW-1:0];
        ll[i] <= mag[i][DW-1:0] * mag[i][DW-1:0];
      end
      neg5 <= neg4;

      for (int i = 0; i < 3; i++) begin
        sq[i] <= ((2*MW)'(hh[i]) << (2 * DW)) + ((2*MW)'(hl[i]) << (DW + 1))
                 + (2*MW)'(ll[i]);
      end
      neg6 <= neg5;

      s6   <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      deg6 <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= sq[i];
      end
    end
  end

endmodule

>>> design/tun_cell.sv
// ----------------------------------------------------------------------------
// tun_cell
// One quotient bit of each normal component by restoring trial on residuals.
// ----------------------------------------------------------------------------
module tun_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [tun_pkg::KW-1:0] bit_pos,
  input  tun_pkg::cell_t        prev,
  output tun_pkg::cell_t        cur
);
  import tun_pkg::*;

  logic [RW-1:0] s_wide;
  logic [RW-1:0] trial [3];
  cell_t         cur_next;

  // residual r = 4*c^2*4^F - (2q-1)^2*S, p = (2q-1)*S
  always_comb begin
    s_wide   = RW'(prev.s);
    cur_next = prev;
    for (int i = 0; i < 3; i++) begin
      trial[i] = prev.r[i] - ((prev.p[i] << (int'(bit_pos) + 2))
                 + (s_wide << (2 * int'(bit_pos) + 2)));
      if (!trial[i][RW-1]) begin
        cur_next.r[i] = trial[i];
        cur_next.p[i] = prev.p[i] + (s_wide << (int'(bit_pos) + 1));
        cur_next.q[i] = prev.q[i] | (QW'(1) << bit_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= cur_next;
    end
  end

endmodule
